// ===== sv/gcp_pkg.sv =====
// shared types, constants and opcode decode for the gpu command port
package gcp_pkg;

  localparam int unsigned MaxPacketWords = 16;
  localparam int unsigned LenW           = 4;

  localparam logic [31:0] StatusReset = 32'h1480_2000;

  // render port opcodes
  localparam logic [7:0] OpPolyFlat3  = 8'h02;
  localparam logic [7:0] OpCopyToVram = 8'hA0;
  localparam logic [7:0] OpCopyFrVram = 8'hC0;
  localparam logic [7:0] OpQuadFlat   = 8'h28;
  localparam logic [7:0] OpTriShade   = 8'h30;
  localparam logic [7:0] OpQuadShade  = 8'h38;
  localparam logic [7:0] OpQuadTex    = 8'h2C;
  localparam logic [7:0] OpDrawMode   = 8'hE1;
  localparam logic [7:0] OpAreaTl     = 8'hE3;
  localparam logic [7:0] OpAreaBr     = 8'hE4;
  localparam logic [7:0] OpMaskBit    = 8'hE6;

  // control port opcodes
  localparam logic [7:0] CtlReset      = 8'h00;
  localparam logic [7:0] CtlDropPacket = 8'h01;
  localparam logic [7:0] CtlIrqAck     = 8'h02;
  localparam logic [7:0] CtlDispEnable = 8'h03;
  localparam logic [7:0] CtlDmaDir     = 8'h04;
  localparam logic [7:0] CtlDispStart  = 8'h05;
  localparam logic [7:0] CtlDispMode   = 8'h08;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic emit_start;
    logic emit_step;
    logic emitting;
  } gcp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic complete;
    logic emit_last;
  } gcp_stat_t;

  function automatic logic [LenW-1:0] packet_size(input logic [7:0] op);
    logic [LenW-1:0] n;
    case (op)
      OpPolyFlat3, OpCopyToVram, OpCopyFrVram: n = LenW'(3);
      OpQuadFlat:  n = LenW'(5);
      OpTriShade:  n = LenW'(6);
      OpQuadShade: n = LenW'(8);
      OpQuadTex:   n = LenW'(9);
      default:     n = '0;
    endcase
    return n;
  endfunction

endpackage

// ===== sv/gcp_ctrl.sv =====
// handshake controller for the gpu command port
module gcp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  gcp_pkg::gcp_stat_t stat_i,
  output gcp_pkg::gcp_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RESP = 3'b010,
    S_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   accept;
  logic   done_out;

  // the final result of the current item leaves this cycle
  assign done_out   = out_ready_i &&
                      ((state_q == S_RESP) || ((state_q == S_EMIT) && stat_i.emit_last));
  assign in_ready_o = (state_q == S_IDLE) || done_out;
  assign accept     = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == S_RESP) || (state_q == S_EMIT);

  assign cmd_o.accept     = accept;
  assign cmd_o.emit_start = accept && stat_i.complete;
  assign cmd_o.emit_step  = (state_q == S_EMIT) && out_ready_i && !stat_i.emit_last;
  assign cmd_o.emitting   = (state_q == S_EMIT);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE, S_RESP, S_EMIT: begin
        if (accept) begin
          state_d = stat_i.complete ? S_EMIT : S_RESP;
        end else if (done_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/gcp_dp.sv =====
// datapath: status, drawing area, display start and packet buffer
module gcp_dp #(
  parameter int unsigned MaxWords = gcp_pkg::MaxPacketWords
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gcp_pkg::gcp_cmd_t  cmd_i,
  output gcp_pkg::gcp_stat_t stat_o,
  input  logic               command_i,
  input  logic [31:0]        word_i,
  output logic [31:0]        gpu_status_o,
  output logic [9:0]         area_left_o,
  output logic [9:0]         area_top_o,
  output logic [9:0]         area_right_o,
  output logic [9:0]         area_bottom_o,
  output logic [9:0]         disp_x_o,
  output logic [8:0]         disp_y_o,
  output logic [31:0]        packet_word_o,
  output logic [3:0]         packet_pos_o,
  output logic               word_valid_o,
  output logic               last_o
);

  localparam int unsigned LenW  = gcp_pkg::LenW;
  localparam int unsigned FillW = $clog2(MaxWords + 1);
  localparam int unsigned IdxW  = $clog2(MaxWords);

  logic [31:0]     status_q, status_d;
  logic [19:0]     area_tl_q, area_tl_d;
  logic [19:0]     area_br_q, area_br_d;
  logic [18:0]     disp_q, disp_d;
  logic [LenW-1:0] len_q, len_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [LenW-1:0] emit_len_q;
  logic [LenW-1:0] emit_idx_q;
  logic [31:0]     buf_q [MaxWords];

  logic [7:0]       op;
  logic [LenW-1:0]  eff_len;
  logic [FillW-1:0] eff_fill;
  logic             store_en;
  logic [FillW-1:0] fill_next;
  logic             complete;

  assign op = word_i[31:24];

  // packet length and slot after the opcode of this render write
  assign eff_len   = (len_q == '0) ? gcp_pkg::packet_size(op) : len_q;
  assign eff_fill  = (len_q == '0) ? '0 : fill_q;
  assign store_en  = !command_i && (eff_len != '0) && (eff_fill < FillW'(MaxWords));
  assign fill_next = store_en ? eff_fill + FillW'(1) : eff_fill;
  assign complete  = !command_i && (eff_len != '0) && (fill_next >= FillW'(eff_len));

  assign stat_o.complete  = complete;
  assign stat_o.emit_last = (emit_idx_q == emit_len_q - LenW'(1));

  always_comb begin
    status_d  = status_q;
    area_tl_d = area_tl_q;
    area_br_d = area_br_q;
    disp_d    = disp_q;
    len_d     = len_q;
    fill_d    = fill_q;
    if (command_i) begin
      case (op)
        gcp_pkg::CtlReset: begin
          status_d  = gcp_pkg::StatusReset;
          area_tl_d = '0;
          area_br_d = '0;
          disp_d    = '0;
          len_d     = '0;
          fill_d    = '0;
        end
        gcp_pkg::CtlDropPacket: begin
          len_d  = '0;
          fill_d = '0;
        end
        gcp_pkg::CtlIrqAck:     status_d[31] = 1'b0;
        gcp_pkg::CtlDispEnable: status_d[23] = word_i[0];
        gcp_pkg::CtlDmaDir:     status_d[30:29] = word_i[1:0];
        gcp_pkg::CtlDispStart:  disp_d = word_i[18:0];
        gcp_pkg::CtlDispMode: begin
          status_d[22:17] = word_i[5:0];
          status_d[16]    = word_i[6];
          status_d[14]    = 1'b0;
        end
        default: ;
      endcase
    end else begin
      if (len_q == '0) begin
        case (op)
          gcp_pkg::OpDrawMode: status_d[10:0] = word_i[10:0];
          gcp_pkg::OpAreaTl:   area_tl_d = word_i[19:0];
          gcp_pkg::OpAreaBr:   area_br_d = word_i[19:0];
          gcp_pkg::OpMaskBit:  status_d[24] = word_i[0];
          default: ;
        endcase
      end
      if (complete) begin
        len_d  = '0;
        fill_d = '0;
      end else begin
        len_d  = eff_len;
        fill_d = fill_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q   <= gcp_pkg::StatusReset;
      area_tl_q  <= '0;
      area_br_q  <= '0;
      disp_q     <= '0;
      len_q      <= '0;
      fill_q     <= '0;
      emit_len_q <= '0;
      emit_idx_q <= '0;
    end else begin
      if (cmd_i.accept) begin
        status_q  <= status_d;
        area_tl_q <= area_tl_d;
        area_br_q <= area_br_d;
        disp_q    <= disp_d;
        len_q     <= len_d;
        fill_q    <= fill_d;
      end
      if (cmd_i.emit_start) begin
        emit_len_q <= eff_len;
        emit_idx_q <= '0;
      end else if (cmd_i.emit_step) begin
        emit_idx_q <= emit_idx_q + LenW'(1);
      end
    end
  end

  // packet buffer, opcode word and payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && store_en) begin
      buf_q[eff_fill[IdxW-1:0]] <= word_i;
    end
  end

  assign gpu_status_o  = status_q;
  assign area_left_o   = area_tl_q[9:0];
  assign area_top_o    = area_tl_q[19:10];
  assign area_right_o  = area_br_q[9:0];
  assign area_bottom_o = area_br_q[19:10];
  assign disp_x_o      = disp_q[9:0];
  assign disp_y_o      = disp_q[18:10];
  assign packet_word_o = cmd_i.emitting ? buf_q[IdxW'(emit_idx_q)] : '0;
  assign packet_pos_o  = cmd_i.emitting ? emit_idx_q : '0;
  assign word_valid_o  = cmd_i.emitting;
  assign last_o        = !cmd_i.emitting || stat_o.emit_last;

endmodule

// ===== sv/gpu_command_port_top.sv =====
// gpu command port: render/control port front end with packet collection
// latency: the first result of an item is registered and shown in the cycle after it is accepted
// throughput: one item a cycle while results are taken at once; after an item that
//   completes a packet of n words the next item is taken with the last word, one word a cycle
// reset: rst_ni asynchronous active low; status resets to its power-on value,
//   area, display start and packet state clear, the packet buffer is not cleared
module gpu_command_port_top #(
  parameter int unsigned MaxPacketWords = gcp_pkg::MaxPacketWords
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input item channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [31:0] word_i,
  // result item channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] gpu_status_o,
  output logic [9:0]  area_left_o,
  output logic [9:0]  area_top_o,
  output logic [9:0]  area_right_o,
  output logic [9:0]  area_bottom_o,
  output logic [9:0]  disp_x_o,
  output logic [8:0]  disp_y_o,
  output logic [31:0] packet_word_o,
  output logic [3:0]  packet_pos_o,
  output logic        word_valid_o,
  output logic        last_o
);

  // control and status between the sequencer and the datapath
  gcp_pkg::gcp_cmd_t  cmd;
  gcp_pkg::gcp_stat_t stat;

  // sequencer: takes items, then shows one result or walks the packet words
  gcp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: opcode decode, state registers and packet buffer
  gcp_dp #(
    .MaxWords (MaxPacketWords)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .command_i     (command_i),
    .word_i        (word_i),
    .gpu_status_o  (gpu_status_o),
    .area_left_o   (area_left_o),
    .area_top_o    (area_top_o),
    .area_right_o  (area_right_o),
    .area_bottom_o (area_bottom_o),
    .disp_x_o      (disp_x_o),
    .disp_y_o      (disp_y_o),
    .packet_word_o (packet_word_o),
    .packet_pos_o  (packet_pos_o),
    .word_valid_o  (word_valid_o),
    .last_o        (last_o)
  );

endmodule

// ===== test/tb_gpu_command_port_top.sv =====
// testbench for gpu_command_port_top: directed table plus random packets against a predictor
`timescale 1ns / 1ps

module tb_gpu_command_port_top;

  localparam int unsigned RandomItems = 83;
  localparam int unsigned StallLimit  = 2000;  // cycles with no handshake on either side
  localparam int unsigned DrainCycles = 12;    // settle time after the last result

  // one result item as the block shows it
  typedef struct packed {
    logic [31:0] status;
    logic [9:0]  area_left;
    logic [9:0]  area_top;
    logic [9:0]  area_right;
    logic [9:0]  area_bottom;
    logic [9:0]  disp_x;
    logic [8:0]  disp_y;
    logic [31:0] pword;
    logic [3:0]  pos;
    logic        wvalid;
    logic        last;
  } port_result_t;

  // one row of the directed table; typed rows carry their own expected result
  typedef struct packed {
    logic         cmd;
    logic [31:0]  w;
    logic         typed;
    port_result_t want;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        command;
  logic [31:0] word;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] gpu_status;
  logic [9:0]  area_left;
  logic [9:0]  area_top;
  logic [9:0]  area_right;
  logic [9:0]  area_bottom;
  logic [9:0]  disp_x;
  logic [8:0]  disp_y;
  logic [31:0] packet_word;
  logic [3:0]  packet_pos;
  logic        word_valid;
  logic        last;

  gpu_command_port_top DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .command_i     (command),
    .word_i        (word),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .gpu_status_o  (gpu_status),
    .area_left_o   (area_left),
    .area_top_o    (area_top),
    .area_right_o  (area_right),
    .area_bottom_o (area_bottom),
    .disp_x_o      (disp_x),
    .disp_y_o      (disp_y),
    .packet_word_o (packet_word),
    .packet_pos_o  (packet_pos),
    .word_valid_o  (word_valid),
    .last_o        (last)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // predictor state: a shadow of the command port registers
  // ---------------------------------------------------------------------------
  logic [31:0] status_shadow;
  logic [3:0]  pkt_len_shadow;
  logic [3:0]  pkt_fill_shadow;
  logic [31:0] pkt_words_shadow [gcp_pkg::MaxPacketWords];
  logic [9:0]  left_shadow, top_shadow, right_shadow, bottom_shadow;
  logic [9:0]  dx_shadow;
  logic [8:0]  dy_shadow;

  port_result_t results_due [$];  // results predicted but not yet seen, oldest first

  int unsigned field_errors;
  int unsigned words_sent;
  int unsigned burst_left;
  int unsigned idle_cycles;

  // power-on / full-reset view of the registers
  function automatic void clear_shadow();
    status_shadow   = gcp_pkg::StatusReset;
    pkt_len_shadow  = '0;
    pkt_fill_shadow = '0;
    left_shadow     = '0;
    top_shadow      = '0;
    right_shadow    = '0;
    bottom_shadow   = '0;
    dx_shadow       = '0;
    dy_shadow       = '0;
  endfunction

  // packet length in words for a render opcode, zero when it starts no packet
  function automatic logic [3:0] packet_words_for(input logic [7:0] op);
    case (op)
      gcp_pkg::OpPolyFlat3, gcp_pkg::OpCopyToVram, gcp_pkg::OpCopyFrVram: return 4'd3;
      gcp_pkg::OpQuadFlat:  return 4'd5;
      gcp_pkg::OpTriShade:  return 4'd6;
      gcp_pkg::OpQuadShade: return 4'd8;
      gcp_pkg::OpQuadTex:   return 4'd9;
      default:              return 4'd0;
    endcase
  endfunction

  // snapshot of the shadow registers as one result
  function automatic void queue_result(input logic [31:0] pw, input logic [3:0] pos,
                                       input logic wv, input logic fin);
    port_result_t r;
    r.status      = status_shadow;
    r.area_left   = left_shadow;
    r.area_top    = top_shadow;
    r.area_right  = right_shadow;
    r.area_bottom = bottom_shadow;
    r.disp_x      = dx_shadow;
    r.disp_y      = dy_shadow;
    r.pword       = pw;
    r.pos         = pos;
    r.wvalid      = wv;
    r.last        = fin;
    results_due.push_back(r);
  endfunction

  // apply one port write to the shadow and queue every result it causes
  function automatic void apply_port_write(input logic cmd, input logic [31:0] w);
    logic [7:0] op;
    logic [3:0] n;
    op = w[31:24];
    if (cmd) begin
      case (op)
        gcp_pkg::CtlReset:      clear_shadow();
        gcp_pkg::CtlDropPacket: begin
          pkt_len_shadow  = '0;
          pkt_fill_shadow = '0;
        end
        gcp_pkg::CtlIrqAck:     status_shadow[31] = 1'b0;
        gcp_pkg::CtlDispEnable: status_shadow[23] = w[0];
        gcp_pkg::CtlDmaDir:     status_shadow[30:29] = w[1:0];
        gcp_pkg::CtlDispStart: begin
          dx_shadow = w[9:0];
          dy_shadow = w[18:10];
        end
        gcp_pkg::CtlDispMode: begin
          // bit 14 clears, bits 22..17 from word 5..0, bit 16 from word bit 6
          status_shadow[14]    = 1'b0;
          status_shadow[22:16] = {w[5:0], w[6]};
        end
        default: ;
      endcase
      queue_result('0, '0, 1'b0, 1'b1);
      return;
    end
    // render port: the top byte is an opcode only when no packet is open
    if (pkt_len_shadow == 0) begin
      case (op)
        gcp_pkg::OpDrawMode: status_shadow[10:0] = w[10:0];
        gcp_pkg::OpAreaTl: begin
          left_shadow = w[9:0];
          top_shadow  = w[19:10];
        end
        gcp_pkg::OpAreaBr: begin
          right_shadow  = w[9:0];
          bottom_shadow = w[19:10];
        end
        gcp_pkg::OpMaskBit: status_shadow[24] = w[0];
        default: begin
          pkt_len_shadow  = packet_words_for(op);
          pkt_fill_shadow = '0;
        end
      endcase
    end
    if (pkt_len_shadow != 0) begin
      pkt_words_shadow[pkt_fill_shadow] = w;
      pkt_fill_shadow = pkt_fill_shadow + 4'd1;
    end
    if (pkt_len_shadow != 0 && pkt_fill_shadow >= pkt_len_shadow) begin
      n = pkt_len_shadow;
      pkt_len_shadow  = '0;
      pkt_fill_shadow = '0;
      for (int i = 0; i < n; i++)
        queue_result(pkt_words_shadow[i], 4'(i), 1'b1, (i == n - 1));
    end else begin
      queue_result('0, '0, 1'b0, 1'b1);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // directed row with a single result typed in by hand
  function automatic dir_row_t row_typed(input logic cmd, input logic [31:0] w,
                                         input logic [31:0] st,
                                         input logic [9:0] l, input logic [9:0] t,
                                         input logic [9:0] r, input logic [9:0] b,
                                         input logic [9:0] dx, input logic [8:0] dy);
    dir_row_t row;
    row.cmd   = cmd;
    row.w     = w;
    row.typed = 1'b1;
    row.want  = '{st, l, t, r, b, dx, dy, 32'h0, 4'h0, 1'b0, 1'b1};
    return row;
  endfunction

  // directed row checked against the predictor
  function automatic dir_row_t row_pred(input logic cmd, input logic [31:0] w);
    dir_row_t row;
    row       = '0;
    row.cmd   = cmd;
    row.w     = w;
    return row;
  endfunction

  // random control word, mostly known opcodes, a few resets, drops and unknowns
  function automatic logic [31:0] random_control_word();
    logic [7:0] op;
    case ($urandom_range(0, 15))
      0:       op = gcp_pkg::CtlReset;
      1:       op = gcp_pkg::CtlDropPacket;
      2:       op = 8'($urandom);
      3, 4:    op = gcp_pkg::CtlIrqAck;
      5, 6:    op = gcp_pkg::CtlDispEnable;
      7, 8:    op = gcp_pkg::CtlDmaDir;
      9, 10, 11: op = gcp_pkg::CtlDispStart;
      default: op = gcp_pkg::CtlDispMode;
    endcase
    return {op, 24'($urandom)};
  endfunction

  function automatic logic [7:0] random_packet_op();
    case ($urandom_range(0, 6))
      0:       return gcp_pkg::OpPolyFlat3;
      1:       return gcp_pkg::OpCopyToVram;
      2:       return gcp_pkg::OpCopyFrVram;
      3:       return gcp_pkg::OpQuadFlat;
      4:       return gcp_pkg::OpTriShade;
      5:       return gcp_pkg::OpQuadShade;
      default: return gcp_pkg::OpQuadTex;
    endcase
  endfunction

  // present one item and hold it until accepted; the sender runs in bursts
  task automatic send_word(input logic cmd, input logic [31:0] w,
                           input logic typed, input port_result_t want);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      // now and then a long burst with no gaps at all
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left = burst_left - 1;
    apply_port_write(cmd, w);
    if (typed) begin
      // hand-typed rows replace the predicted single result
      void'(results_due.pop_back());
      results_due.push_back(want);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    word     <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // hold the sender until every predicted result has come out
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s got %h expected %h", $time, what, got, want);
    field_errors++;
  endtask

  // ---------------------------------------------------------------------------
  // result side: stall pattern and checker
  // ---------------------------------------------------------------------------
  int unsigned stall_mode;
  int unsigned stall_span;

  // receiver switches between always ready, coin flip and mostly stalled
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_span <= $urandom_range(16, 64);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // compare every accepted result with the oldest prediction
  always @(posedge clk) begin
    port_result_t got;
    port_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {gpu_status, area_left, area_top, area_right, area_bottom,
             disp_x, disp_y, packet_word, packet_pos, word_valid, last};
      if (results_due.size() == 0) begin
        report_mismatch("result with none due, gpu_status", got.status, '0);
      end else begin
        want = results_due.pop_front();
        if (got.status !== want.status)
          report_mismatch("gpu_status", got.status, want.status);
        if (got.area_left !== want.area_left)
          report_mismatch("area_left", 32'(got.area_left), 32'(want.area_left));
        if (got.area_top !== want.area_top)
          report_mismatch("area_top", 32'(got.area_top), 32'(want.area_top));
        if (got.area_right !== want.area_right)
          report_mismatch("area_right", 32'(got.area_right), 32'(want.area_right));
        if (got.area_bottom !== want.area_bottom)
          report_mismatch("area_bottom", 32'(got.area_bottom), 32'(want.area_bottom));
        if (got.disp_x !== want.disp_x)
          report_mismatch("disp_x", 32'(got.disp_x), 32'(want.disp_x));
        if (got.disp_y !== want.disp_y)
          report_mismatch("disp_y", 32'(got.disp_y), 32'(want.disp_y));
        if (got.pword !== want.pword)
          report_mismatch("packet_word", got.pword, want.pword);
        if (got.pos !== want.pos)
          report_mismatch("packet_pos", 32'(got.pos), 32'(want.pos));
        if (got.wvalid !== want.wvalid)
          report_mismatch("word_valid", 32'(got.wvalid), 32'(want.wvalid));
        if (got.last !== want.last)
          report_mismatch("last", 32'(got.last), 32'(want.last));
      end
    end
  end

  // watchdog: too long with no handshake on either side ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, StallLimit);
      $display("gpu_command_port_top regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  dir_row_t directed_rows [$];

  initial begin
    dir_row_t   row;
    logic [7:0] op;
    logic [3:0] n;
    int unsigned pick;
    int unsigned dir_count;
    bit         paused;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    command      = 1'b0;
    word         = '0;
    out_ready    = 1'b0;
    stall_mode   = 0;
    stall_span   = 0;
    field_errors = 0;
    words_sent   = 0;
    burst_left   = 0;
    idle_cycles  = 0;
    paused       = 1'b0;
    clear_shadow();

    // status walk from power-on, every state op at its extremes
    directed_rows.push_back(row_typed(1'b0, 32'h0000_0000, 32'h1480_2000,
                                      '0, '0, '0, '0, '0, '0));   // unknown render opcode
    directed_rows.push_back(row_typed(1'b0, 32'hE1FF_FFFF, 32'h1480_27FF,
                                      '0, '0, '0, '0, '0, '0));
    directed_rows.push_back(row_typed(1'b0, 32'hE3FF_FFFF, 32'h1480_27FF,
                                      10'h3FF, 10'h3FF, '0, '0, '0, '0));
    directed_rows.push_back(row_typed(1'b0, 32'hE4FF_FFFF, 32'h1480_27FF,
                                      10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, '0, '0));
    directed_rows.push_back(row_typed(1'b0, 32'hE6FF_FFFF, 32'h1580_27FF,
                                      10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, '0, '0));
    directed_rows.push_back(row_typed(1'b1, 32'h05FF_FFFF, 32'h1580_27FF,
                                      10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 9'h1FF));
    directed_rows.push_back(row_typed(1'b1, 32'h0300_0000, 32'h1500_27FF,
                                      10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 9'h1FF));
    directed_rows.push_back(row_typed(1'b1, 32'h0400_0003, 32'h7500_27FF,
                                      10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 9'h1FF));
    directed_rows.push_back(row_typed(1'b1, 32'h0800_007F, 32'h757F_27FF,
                                      10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 9'h1FF));
    directed_rows.push_back(row_typed(1'b1, 32'h0200_0000, 32'h757F_27FF,
                                      10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 9'h1FF));
    // unknown control opcode changes nothing
    directed_rows.push_back(row_typed(1'b1, 32'hFF12_3456, 32'h757F_27FF,
                                      10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 9'h1FF));
    // full reset back to power-on values
    directed_rows.push_back(row_typed(1'b1, 32'h0000_0000, 32'h1480_2000,
                                      '0, '0, '0, '0, '0, '0));
    // shortest packet with a control write in the middle that keeps it open
    directed_rows.push_back(row_pred(1'b0, {gcp_pkg::OpPolyFlat3, 24'hAA_AAAA}));
    directed_rows.push_back(row_pred(1'b0, 32'hFFFF_FFFF));
    directed_rows.push_back(row_pred(1'b1, {gcp_pkg::CtlDispStart, 24'h55_5555}));
    directed_rows.push_back(row_pred(1'b0, 32'h0000_0000));
    // packet dropped before it completes
    directed_rows.push_back(row_pred(1'b0, {gcp_pkg::OpTriShade, 24'hFE_DCBA}));
    directed_rows.push_back(row_pred(1'b1, {gcp_pkg::CtlDropPacket, 24'h00_0000}));
    // longest packet, payload words that look like opcodes
    directed_rows.push_back(row_pred(1'b0, {gcp_pkg::OpQuadTex, 24'h00_0000}));
    directed_rows.push_back(row_pred(1'b0, {gcp_pkg::OpDrawMode, 24'h00_0000}));
    directed_rows.push_back(row_pred(1'b0, {gcp_pkg::OpQuadTex, 24'hFF_FFFF}));
    directed_rows.push_back(row_pred(1'b0, 32'h8000_0001));
    directed_rows.push_back(row_pred(1'b0, 32'h7FFF_FFFE));
    directed_rows.push_back(row_pred(1'b0, 32'h1234_5678));
    directed_rows.push_back(row_pred(1'b0, 32'hDEAD_BEEF));
    directed_rows.push_back(row_pred(1'b0, 32'h0000_0000));
    directed_rows.push_back(row_pred(1'b0, 32'hFFFF_FFFF));
    dir_count = directed_rows.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_word(row.cmd, row.w, row.typed, row.want);
    end

    // let the directed part drain before random traffic starts
    wait_results_drained();

    // random part: mostly whole packets with random payload, plus state ops and noise
    while (words_sent < dir_count + RandomItems) begin
      if (!paused && words_sent >= dir_count + RandomItems / 2) begin
        wait_results_drained();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        op = random_packet_op();
        n  = packet_words_for(op);
        send_word(1'b0, {op, 24'($urandom)}, 1'b0, '0);
        for (int k = 1; k < n; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 6) begin
            // control write inside the packet, may also kill it
            send_word(1'b1, random_control_word(), 1'b0, '0);
          end else if (pick < 9) begin
            // broken sequence: packet abandoned
            send_word(1'b1, {(pick < 8) ? gcp_pkg::CtlDropPacket : gcp_pkg::CtlReset,
                             24'($urandom)}, 1'b0, '0);
            break;
          end
          send_word(1'b0, $urandom, 1'b0, '0);
        end
      end else if (pick < 75) begin
        case ($urandom_range(0, 3))
          0:       op = gcp_pkg::OpDrawMode;
          1:       op = gcp_pkg::OpAreaTl;
          2:       op = gcp_pkg::OpAreaBr;
          default: op = gcp_pkg::OpMaskBit;
        endcase
        send_word(1'b0, {op, 24'($urandom)}, 1'b0, '0);
      end else if (pick < 92) begin
        send_word(1'b1, random_control_word(), 1'b0, '0);
      end else begin
        send_word(1'($urandom_range(0, 1)), $urandom, 1'b0, '0);
      end
    end

    wait_results_drained();
    repeat (DrainCycles) @(posedge clk);

    if (field_errors == 0 && results_due.size() == 0) begin
      $display("gpu_command_port_top regression: pass");
    end else begin
      $display("gpu_command_port_top regression: fail");
    end
    $finish;
  end

endmodule
